// ===== hw/rtl/ntc_steinhart_hart_temp_defines.svh =====
// Assertion macros used by the NTC temperature top module.
`ifndef NTC_STEINHART_HART_TEMP_DEFINES_SVH
`define NTC_STEINHART_HART_TEMP_DEFINES_SVH

// Implication check, disabled while reset is asserted.
`define NSHTC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Invariant check on every clock edge out of reset.
`define NSHTC_ASSERT_ALW(lbl, clk, rstn, cons, msg) \
    `NSHTC_ASSERT_IMP(lbl, clk, rstn, 1'b1, cons, msg)

`endif

// ===== hw/rtl/nshtc_pkg.sv =====
// Shared types and constants for the NTC Steinhart-Hart temperature pipeline.
`default_nettype none

package nshtc_pkg;

    localparam int RAW_W   = 13;
    localparam int FS_W    = 13;
    localparam int SUP_W   = 13;
    localparam int RREF_W  = 20;
    localparam int COEF_W  = 32;
    localparam int VNUM_W  = FS_W + RAW_W - 1;
    localparam int NUM_W   = VNUM_W + RREF_W;
    localparam int K_W     = 6;
    localparam int FRAC_W  = 24;
    localparam int LOG_W   = K_W + FRAC_W;
    localparam int INV_W   = 50;
    localparam int TC_W    = 19;
    localparam int TEMP_W  = 16;
    localparam int STAT_W  = 2;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_ADC_FS  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_SUPPLY  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_RREF    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_COEFF_A = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_COEFF_B = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_COEFF_C = 3'd5;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_DIV   = 2'd2;

    localparam logic signed [TC_W-1:0] T_MIN   = -19'sd10000;
    localparam logic signed [TC_W-1:0] T_MAX   = 19'sd30000;
    localparam logic signed [TC_W-1:0] BODY_LO = 19'sd2000;
    localparam logic signed [TC_W-1:0] BODY_HI = 19'sd4500;

    typedef struct packed {
        logic [FS_W-1:0]          adc_fs;
        logic [SUP_W-1:0]         supply;
        logic [RREF_W-1:0]        rref;
        logic signed [COEF_W-1:0] coeff_a;
        logic signed [COEF_W-1:0] coeff_b;
        logic signed [COEF_W-1:0] coeff_c;
    } cfg_t;

    typedef struct packed {
        logic              vld;
        logic [STAT_W-1:0] status;
    } side_t;

endpackage

`default_nettype wire

// ===== hw/rtl/nshtc_front.sv =====
// Front end: range check, millivolt scaling, divider numerator and denominator.
`default_nettype none

module nshtc_front #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          adv,
    input  nshtc_pkg::cfg_t               cfg,
    input  logic                          s_vld,
    input  logic signed [nshtc_pkg::RAW_W-1:0] raw,
    output nshtc_pkg::side_t              side_o,
    output logic [nshtc_pkg::NUM_W-1:0]   num_o,
    output logic [nshtc_pkg::NUM_W-1:0]   den_o
);
    import nshtc_pkg::*;

    localparam int DEN_W = ((SUP_W + SAMPLE_BITS > VNUM_W) ? SUP_W + SAMPLE_BITS : VNUM_W) + 1;
    localparam logic signed [15:0] RAW_MAX = 16'((1 << SAMPLE_BITS) - 1);
    localparam logic signed [DEN_W-1:0] SCALE = DEN_W'(1 << SAMPLE_BITS);

    side_t              side1_reg, side2_reg;
    logic [VNUM_W-1:0]  vnum_reg;
    logic [NUM_W-1:0]   num_reg, den_reg;

    logic signed [15:0]      raw_ext;
    logic [STAT_W-1:0]       stat1_next, stat2_next;
    logic [VNUM_W-1:0]       vnum_next;
    logic signed [DEN_W-1:0] den_s;
    logic [NUM_W-1:0]        prod, num_next;

    always_comb begin
        raw_ext    = 16'(raw);
        stat1_next = (raw_ext <= 16'sd0 || raw_ext >= RAW_MAX) ? STAT_RANGE : STAT_OK;
        vnum_next  = raw[RAW_W-2:0] * cfg.adc_fs;

        den_s = $signed(DEN_W'(cfg.supply) << SAMPLE_BITS) - $signed(DEN_W'(vnum_reg));
        stat2_next = side1_reg.status;
        if (side1_reg.status == STAT_OK && den_s <= SCALE) begin
            stat2_next = STAT_DIV;
        end
        // zero full scale or zero reference: keep the log argument at one
        prod     = cfg.rref * vnum_reg;
        num_next = (prod == '0) ? NUM_W'(1) : prod;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side1_reg <= '0;
            side2_reg <= '0;
        end else if (adv) begin
            side1_reg <= '{vld: s_vld, status: stat1_next};
            side2_reg <= '{vld: side1_reg.vld, status: stat2_next};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            vnum_reg <= vnum_next;
            num_reg  <= num_next;
            den_reg  <= NUM_W'(den_s[DEN_W-2:0]);
        end
    end

    assign side_o = side2_reg;
    assign num_o  = num_reg;
    assign den_o  = den_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/nshtc_log.sv =====
// Two-lane pipelined log2 in Q24 by repeated squaring, one fraction bit per stage.
`default_nettype none

module nshtc_log (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        adv,
    input  nshtc_pkg::side_t            side_i,
    input  logic [nshtc_pkg::NUM_W-1:0] num_i,
    input  logic [nshtc_pkg::NUM_W-1:0] den_i,
    output nshtc_pkg::side_t            side_o,
    output logic [nshtc_pkg::LOG_W-1:0] lnum_o,
    output logic [nshtc_pkg::LOG_W-1:0] lden_o
);
    import nshtc_pkg::*;

    localparam int LANES  = 2;
    localparam int MANT_W = 31;

    function automatic logic [K_W-1:0] msb_pos(input logic [NUM_W-1:0] x);
        logic [K_W-1:0] pos;
        pos = '0;
        for (int i = 0; i < NUM_W; i++) begin
            if (x[i]) pos = K_W'(i);
        end
        return pos;
    endfunction

    side_t side_a_reg;
    side_t side_st_reg [0:FRAC_W];
    logic [NUM_W-1:0] x_in [LANES];
    logic [LOG_W-1:0] lg [LANES];

    assign x_in[0] = num_i;
    assign x_in[1] = den_i;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_a_reg <= '0;
            for (int j = 0; j <= FRAC_W; j++) side_st_reg[j] <= '0;
        end else if (adv) begin
            side_a_reg     <= side_i;
            side_st_reg[0] <= side_a_reg;
            for (int j = 0; j < FRAC_W; j++) side_st_reg[j+1] <= side_st_reg[j];
        end
    end

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        logic [NUM_W-1:0]  xa_reg;
        logic [K_W-1:0]    ka_reg;
        logic [MANT_W-1:0] m_st_reg [0:FRAC_W];
        logic [FRAC_W-1:0] f_st_reg [0:FRAC_W];
        logic [K_W-1:0]    k_st_reg [0:FRAC_W];

        logic [NUM_W-1:0]  xs;
        logic [MANT_W-1:0] m0_next;
        logic [MANT_W-1:0] m_nx [FRAC_W];
        logic [FRAC_W-1:0] f_nx [FRAC_W];

        always_comb begin
            // normalize to Q1.30: mantissa in [1, 2)
            if (ka_reg <= K_W'(MANT_W - 1)) begin
                xs = xa_reg << (K_W'(MANT_W - 1) - ka_reg);
            end else begin
                xs = xa_reg >> (ka_reg - K_W'(MANT_W - 1));
            end
            m0_next = xs[MANT_W-1:0];
        end

        always_comb begin
            logic [2*MANT_W-1:0] sq;
            logic [MANT_W:0]     t;
            for (int j = 0; j < FRAC_W; j++) begin
                sq = m_st_reg[j] * m_st_reg[j];
                t  = sq[2*MANT_W-1:MANT_W-1];
                m_nx[j] = t[MANT_W] ? t[MANT_W:1] : t[MANT_W-1:0];
                f_nx[j] = f_st_reg[j];
                f_nx[j][FRAC_W-1-j] = t[MANT_W];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                xa_reg      <= x_in[g];
                ka_reg      <= msb_pos(x_in[g]);
                m_st_reg[0] <= m0_next;
                f_st_reg[0] <= '0;
                k_st_reg[0] <= ka_reg;
                for (int j = 0; j < FRAC_W; j++) begin
                    m_st_reg[j+1] <= m_nx[j];
                    f_st_reg[j+1] <= f_nx[j];
                    k_st_reg[j+1] <= k_st_reg[j];
                end
            end
        end

        assign lg[g] = {k_st_reg[FRAC_W], f_st_reg[FRAC_W]};
    end

    assign side_o = side_st_reg[FRAC_W];
    assign lnum_o = lg[0];
    assign lden_o = lg[1];

endmodule

`default_nettype wire

// ===== hw/rtl/nshtc_poly.sv =====
// Natural log from the log2 difference, cubic and Steinhart-Hart sum in Q40.
`default_nettype none

module nshtc_poly (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               adv,
    input  nshtc_pkg::cfg_t                    cfg,
    input  nshtc_pkg::side_t                   side_i,
    input  logic [nshtc_pkg::LOG_W-1:0]        lnum_i,
    input  logic [nshtc_pkg::LOG_W-1:0]        lden_i,
    output nshtc_pkg::side_t                   side_o,
    output logic signed [nshtc_pkg::INV_W-1:0] inv_o
);
    import nshtc_pkg::*;

    localparam int L24_W = LOG_W + 1;
    localparam int L16_W = L24_W - 8;
    localparam int LN_W  = 31;
    localparam int P1_W  = L24_W + LN_W;
    localparam int L2_W  = 27;
    localparam int BL_W  = COEF_W + L24_W;
    localparam int BLS_W = BL_W - 24;
    localparam int L3_W  = 32;
    localparam int CL_W  = COEF_W + L3_W - 16;
    localparam logic signed [LN_W-1:0] LN2_Q30 = 31'sd744261118;

    side_t side_reg [7];

    logic signed [L24_W-1:0] d_reg, l24_reg;
    logic signed [P1_W-1:0]  prod_reg;
    logic signed [L16_W-1:0] l16_reg, l16b_reg;
    logic signed [L2_W-1:0]  l2_reg;
    logic signed [BL_W-1:0]  bl_reg;
    logic signed [L3_W-1:0]  l3_reg;
    logic signed [BLS_W-1:0] bls_reg, bls5_reg;
    logic signed [CL_W-1:0]  cl_reg;
    logic signed [INV_W-1:0] inv_reg;

    logic signed [P1_W-1:0]          prod_next;
    logic signed [2*L16_W-1:0]       sq;
    logic signed [BL_W-1:0]          bl_next;
    logic signed [L2_W+L16_W-1:0]    cube;
    logic signed [COEF_W+L3_W-1:0]   cl_full;

    always_comb begin
        prod_next = d_reg * LN2_Q30;
        sq        = l16_reg * l16_reg;
        bl_next   = cfg.coeff_b * l24_reg;
        cube      = l2_reg * l16b_reg;
        cl_full   = cfg.coeff_c * l3_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 7; i++) side_reg[i] <= '0;
        end else if (adv) begin
            side_reg[0] <= side_i;
            for (int i = 0; i < 6; i++) side_reg[i+1] <= side_reg[i];
        end
    end

    // part-selects of signed products give the floored right shifts
    always_ff @(posedge aclk) begin
        if (adv) begin
            d_reg    <= $signed({1'b0, lnum_i}) - $signed({1'b0, lden_i});
            prod_reg <= prod_next;
            l24_reg  <= prod_reg[L24_W+29:30];
            l16_reg  <= prod_reg[L24_W+29:38];
            l2_reg   <= sq[L2_W+15:16];
            bl_reg   <= bl_next;
            l16b_reg <= l16_reg;
            l3_reg   <= cube[L3_W+15:16];
            bls_reg  <= bl_reg[BL_W-1:24];
            cl_reg   <= cl_full[COEF_W+L3_W-1:16];
            bls5_reg <= bls_reg;
            inv_reg  <= INV_W'(cfg.coeff_a) + INV_W'(bls5_reg) + INV_W'(cl_reg);
        end
    end

    assign side_o = side_reg[6];
    assign inv_o  = inv_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/nshtc_div.sv =====
// Pipelined restoring division of 100*2^40 by inv_t, Kelvin offset, saturation.
`default_nettype none

module nshtc_div (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               adv,
    input  nshtc_pkg::side_t                   side_i,
    input  logic signed [nshtc_pkg::INV_W-1:0] inv_i,
    output nshtc_pkg::side_t                   side_o,
    output logic [nshtc_pkg::TEMP_W-1:0]       temp_o,
    output logic                               flag_o
);
    import nshtc_pkg::*;

    localparam int QUO_W = 17;
    localparam int D_W   = INV_W - 1;
    localparam int CMP_W = D_W + QUO_W;
    localparam logic [D_W-1:0] NUM_K = D_W'(64'd100 << 40);
    localparam logic signed [TC_W-1:0] KELVIN = 19'sd27315;

    localparam logic [1:0] KIND_DIV = 2'd0;
    localparam logic [1:0] KIND_MAX = 2'd1;
    localparam logic [1:0] KIND_MIN = 2'd2;

    side_t            side_st_reg [0:QUO_W];
    logic [D_W-1:0]   rem_st_reg  [0:QUO_W];
    logic [D_W-1:0]   d_st_reg    [0:QUO_W];
    logic [QUO_W-1:0] q_st_reg    [0:QUO_W];
    logic [1:0]       kind_st_reg [0:QUO_W];
    side_t            side_out_reg;
    logic [TEMP_W-1:0] temp_reg;
    logic             flag_reg;

    logic [D_W-1:0]   d_in, n_in;
    logic             ovf;
    logic [1:0]       kind_next;
    logic [D_W-1:0]   rem_nx [QUO_W];
    logic [QUO_W-1:0] q_nx   [QUO_W];
    logic signed [TC_W-1:0] tc;
    logic [TEMP_W-1:0] temp_next;
    logic             flag_next;

    always_comb begin
        d_in = inv_i[D_W-1:0];
        n_in = NUM_K + (d_in >> 1);
        // quotient of 2^17 or more saturates anyway
        ovf  = {QUO_W'(0), n_in} >= {d_in, QUO_W'(0)};
        if (inv_i < 0) begin
            kind_next = KIND_MIN;
        end else if (inv_i == '0 || ovf) begin
            kind_next = KIND_MAX;
        end else begin
            kind_next = KIND_DIV;
        end
    end

    always_comb begin
        logic [CMP_W-1:0] sh;
        for (int j = 0; j < QUO_W; j++) begin
            sh = CMP_W'(d_st_reg[j]) << (QUO_W - 1 - j);
            rem_nx[j] = rem_st_reg[j];
            q_nx[j]   = q_st_reg[j];
            if ({QUO_W'(0), rem_st_reg[j]} >= sh) begin
                rem_nx[j] = rem_st_reg[j] - sh[D_W-1:0];
                q_nx[j][QUO_W-1-j] = 1'b1;
            end
        end
    end

    always_comb begin
        tc = $signed({2'b00, q_st_reg[QUO_W]}) - KELVIN;
        case (kind_st_reg[QUO_W])
            KIND_DIV: begin
                flag_next = (tc < BODY_LO) || (tc > BODY_HI);
                if (tc > T_MAX) begin
                    temp_next = T_MAX[TEMP_W-1:0];
                end else if (tc < T_MIN) begin
                    temp_next = T_MIN[TEMP_W-1:0];
                end else begin
                    temp_next = tc[TEMP_W-1:0];
                end
            end
            KIND_MIN: begin
                temp_next = T_MIN[TEMP_W-1:0];
                flag_next = 1'b1;
            end
            default: begin
                temp_next = T_MAX[TEMP_W-1:0];
                flag_next = 1'b1;
            end
        endcase
        if (side_st_reg[QUO_W].status != STAT_OK) begin
            temp_next = '0;
            flag_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j <= QUO_W; j++) side_st_reg[j] <= '0;
            side_out_reg <= '0;
        end else if (adv) begin
            side_st_reg[0] <= side_i;
            for (int j = 0; j < QUO_W; j++) side_st_reg[j+1] <= side_st_reg[j];
            side_out_reg <= side_st_reg[QUO_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            rem_st_reg[0]  <= n_in;
            d_st_reg[0]    <= d_in;
            q_st_reg[0]    <= '0;
            kind_st_reg[0] <= kind_next;
            for (int j = 0; j < QUO_W; j++) begin
                rem_st_reg[j+1]  <= rem_nx[j];
                d_st_reg[j+1]    <= d_st_reg[j];
                q_st_reg[j+1]    <= q_nx[j];
                kind_st_reg[j+1] <= kind_st_reg[j];
            end
            temp_reg <= temp_next;
            flag_reg <= flag_next;
        end
    end

    assign side_o = side_out_reg;
    assign temp_o = temp_reg;
    assign flag_o = flag_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/ntc_steinhart_hart_temp.sv =====
// Throughput: one sample per cycle unless stalled; divider and log2 stages are one bit per stage.
// A stall on m_tready freezes the whole pipeline and drops s_tready in the same cycle.
// Reset (aresetn low, synchronous) clears all valid bits and loads the register defaults.
// No clearing pass: samples are accepted in the first cycle after reset.
`default_nettype none

`include "ntc_steinhart_hart_temp_defines.svh"

module ntc_steinhart_hart_temp #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic        aclk,
    input  logic        aresetn,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // sample stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,  // [12:0] raw_sample
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata   // [15:0] temp_centi_c, [17:16] status, [18] outside_body_range
);
    import nshtc_pkg::*;

    localparam logic [FS_W-1:0]   RST_ADC_FS = 13'd3600;
    localparam logic [SUP_W-1:0]  RST_SUPPLY = 13'd3300;
    localparam logic [RREF_W-1:0] RST_RREF   = 20'd10000;
    localparam logic signed [COEF_W-1:0] RST_COEFF_A = 32'sd1109681500;
    localparam logic signed [COEF_W-1:0] RST_COEFF_B = 32'sd261508400;
    localparam logic signed [COEF_W-1:0] RST_COEFF_C = 32'sd222018;

    cfg_t cfg_reg, cfg_next;
    logic adv, wr_en;
    logic [REG_IDX_W-1:0] reg_idx;

    side_t side_f, side_l, side_p, side_d;
    logic [NUM_W-1:0] num_f, den_f;
    logic [LOG_W-1:0] lnum, lden;
    logic signed [INV_W-1:0] inv_t;
    logic [TEMP_W-1:0] temp;
    logic flag;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (reg_idx)
                REG_ADC_FS:  cfg_next.adc_fs  = pwdata[FS_W-1:0];
                REG_SUPPLY:  cfg_next.supply  = pwdata[SUP_W-1:0];
                REG_RREF:    cfg_next.rref    = pwdata[RREF_W-1:0];
                REG_COEFF_A: cfg_next.coeff_a = $signed(pwdata);
                REG_COEFF_B: cfg_next.coeff_b = $signed(pwdata);
                REG_COEFF_C: cfg_next.coeff_c = $signed(pwdata);
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_ADC_FS:  prdata = 32'(cfg_reg.adc_fs);
            REG_SUPPLY:  prdata = 32'(cfg_reg.supply);
            REG_RREF:    prdata = 32'(cfg_reg.rref);
            REG_COEFF_A: prdata = cfg_reg.coeff_a;
            REG_COEFF_B: prdata = cfg_reg.coeff_b;
            REG_COEFF_C: prdata = cfg_reg.coeff_c;
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{adc_fs: RST_ADC_FS, supply: RST_SUPPLY, rref: RST_RREF,
                         coeff_a: RST_COEFF_A, coeff_b: RST_COEFF_B,
                         coeff_c: RST_COEFF_C};
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // whole pipeline moves when the output slot is free or being drained
    assign adv      = m_tready || !m_tvalid;
    assign s_tready = adv;

    nshtc_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
        .aclk(aclk), .aresetn(aresetn), .adv(adv), .cfg(cfg_reg),
        .s_vld(s_tvalid), .raw($signed(s_tdata[RAW_W-1:0])),
        .side_o(side_f), .num_o(num_f), .den_o(den_f)
    );

    nshtc_log u_log (
        .aclk(aclk), .aresetn(aresetn), .adv(adv), .side_i(side_f),
        .num_i(num_f), .den_i(den_f),
        .side_o(side_l), .lnum_o(lnum), .lden_o(lden)
    );

    nshtc_poly u_poly (
        .aclk(aclk), .aresetn(aresetn), .adv(adv), .cfg(cfg_reg), .side_i(side_l),
        .lnum_i(lnum), .lden_i(lden), .side_o(side_p), .inv_o(inv_t)
    );

    nshtc_div u_div (
        .aclk(aclk), .aresetn(aresetn), .adv(adv), .side_i(side_p), .inv_i(inv_t),
        .side_o(side_d), .temp_o(temp), .flag_o(flag)
    );

    assign m_tvalid = side_d.vld;
    assign m_tdata  = {5'b0, flag, side_d.status, temp};

    `NSHTC_ASSERT_IMP(a_err_zero, aclk, aresetn, m_tvalid && m_tdata[17:16] != STAT_OK,
        m_tdata[15:0] == '0 && !m_tdata[18], "error result carries nonzero payload")

    `NSHTC_ASSERT_IMP(a_stat_code, aclk, aresetn, m_tvalid,
        !m_tdata[17] || !m_tdata[16], "reserved status code on output")

    `NSHTC_ASSERT_IMP(a_temp_range, aclk, aresetn, m_tvalid,
        $signed(m_tdata[15:0]) >= T_MIN && $signed(m_tdata[15:0]) <= T_MAX,
        "temperature outside saturation limits")

    `NSHTC_ASSERT_IMP(a_body_flag, aclk, aresetn, m_tvalid && m_tdata[17:16] == STAT_OK,
        m_tdata[18] == ($signed(m_tdata[15:0]) < BODY_LO || $signed(m_tdata[15:0]) > BODY_HI),
        "body range flag disagrees with temperature")

endmodule

`default_nettype wire
